// ===== src/owm_pkg.sv =====
// Shared types and constants of the single-wire bus master.
package owm_pkg;

  // command codes
  localparam logic [2:0] CMD_RESET    = 3'd0;
  localparam logic [2:0] CMD_WR_BYTE  = 3'd1;
  localparam logic [2:0] CMD_RD_BYTE  = 3'd2;
  localparam logic [2:0] CMD_WR_BIT   = 3'd3;
  localparam logic [2:0] CMD_RD_BIT   = 3'd4;
  localparam logic [2:0] CMD_RD_2BITS = 3'd5;

  // register indexes
  localparam int REG_COUNT = 8;
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRES_WAIT     = 3'd1;
  localparam logic [2:0] REG_PRES_MAX      = 3'd2;
  localparam logic [2:0] REG_WR1_LOW       = 3'd3;
  localparam logic [2:0] REG_WR1_HIGH      = 3'd4;
  localparam logic [2:0] REG_WR0_LOW       = 3'd5;
  localparam logic [2:0] REG_RD_SAMPLE     = 3'd6;
  localparam logic [2:0] REG_RD_RECOVER    = 3'd7;

  localparam int REG_BITS = 10;

  // fixed slot timings in ticks
  localparam logic [REG_BITS-1:0] RESET_RELEASE_US = 10'd15;
  localparam logic [REG_BITS-1:0] READ_LOW_US      = 10'd2;
  localparam logic [REG_BITS-1:0] ZERO_RELEASE_US  = 10'd2;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef logic [REG_COUNT-1:0][REG_BITS-1:0] cfg_regs_t;

  // classified input word
  typedef struct packed {
    logic       is_tick;   // tick word
    logic       start_ok;  // command word with a known code
    logic [2:0] command;
    logic [7:0] write_data;
    logic       line_level;
  } item_t;

  // queue handshake toward the back part
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

endpackage

// ===== src/owm_front.sv =====
// Front part: takes input words, classifies them and queues them.
module owm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [2:0]         command,
  input  logic [7:0]         write_data,
  input  logic               line_level,
  output owm_pkg::queue_out_t q_out,
  input  logic               q_pop
);

  localparam int PTR_BITS = $clog2(owm_pkg::QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(owm_pkg::QUEUE_DEPTH + 1);

  owm_pkg::item_t                mem [owm_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0]           wr_ptr;
  logic [PTR_BITS-1:0]           rd_ptr;
  logic [CNT_BITS-1:0]           count;
  owm_pkg::item_t                entry;
  logic                          push;
  logic                          pop;

  // classify the incoming word
  always_comb begin
    entry.is_tick    = kind;
    entry.start_ok   = !kind && (command <= owm_pkg::CMD_RD_2BITS);
    entry.command    = command;
    entry.write_data = write_data;
    entry.line_level = line_level;
  end

  assign in_ready = (count != CNT_BITS'(owm_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && (count != '0);

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      count <= count + CNT_BITS'(push) - CNT_BITS'(pop);
    end
  end

  assign q_out.valid = (count != '0);
  assign q_out.item  = mem[rd_ptr];

endmodule

// ===== src/owm_back.sv =====
// Back part: bus timing sequencer with a registered result stage.
module owm_back #(
  parameter int TIMER_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  owm_pkg::cfg_regs_t  cfg,
  input  owm_pkg::queue_out_t q_out,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                drive_low,
  output logic                busy_res,
  output logic                done_res,
  output logic [7:0]          read_data,
  output logic                no_presence
);

  // phase codes
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_RST_LOW    = 4'd1;
  localparam logic [3:0] PH_RST_REL    = 4'd2;
  localparam logic [3:0] PH_PRES_WAIT  = 4'd3;
  localparam logic [3:0] PH_PRES_LOW   = 4'd4;
  localparam logic [3:0] PH_WR_LOW     = 4'd5;
  localparam logic [3:0] PH_WR_HIGH    = 4'd6;
  localparam logic [3:0] PH_RD_LOW     = 4'd7;
  localparam logic [3:0] PH_RD_REL     = 4'd8;
  localparam logic [3:0] PH_RD_RECOVER = 4'd9;

  localparam int WIDE = 17;
  localparam logic [WIDE-1:0] TMAX_W = WIDE'((1 << TIMER_BITS) - 1);

  logic [3:0]            phase, phase_next;
  logic [TIMER_BITS-1:0] slot_timer, slot_timer_next;
  logic [3:0]            bit_index, bit_index_next;
  logic [7:0]            shift_data, shift_data_next;
  logic [2:0]            active_command, active_command_next;
  logic                  error_flag, error_flag_next;
  logic                  done;
  logic                  step;
  logic [TIMER_BITS:0]   tnext;
  logic [TIMER_BITS-1:0] cur_len;
  logic                  seg_end;
  logic [3:0]            bits_total;
  logic                  cur_bit;
  owm_pkg::item_t        it;

  // zero acts as one, long values clamp to the timer maximum
  function automatic logic [TIMER_BITS-1:0] seg_len(input logic [owm_pkg::REG_BITS-1:0] v);
    logic [WIDE-1:0] w;
    w = WIDE'(v);
    if (w == '0) begin
      w = WIDE'(1);
    end
    if (w > TMAX_W) begin
      w = TMAX_W;
    end
    return w[TIMER_BITS-1:0];
  endfunction

  assign it      = q_out.item;
  assign step    = q_out.valid && (!out_valid || out_ready);
  assign q_pop   = step;
  assign cur_bit = shift_data[0];
  assign tnext   = {1'b0, slot_timer} + (TIMER_BITS+1)'(1);

  // bits in the current operation
  always_comb begin
    case (active_command)
      owm_pkg::CMD_WR_BYTE, owm_pkg::CMD_RD_BYTE: bits_total = 4'd8;
      owm_pkg::CMD_RD_2BITS:                       bits_total = 4'd2;
      default:                                     bits_total = 4'd1;
    endcase
  end

  // length of the running segment
  always_comb begin
    case (phase)
      PH_RST_LOW:    cur_len = seg_len(cfg[owm_pkg::REG_RESET_LOW]);
      PH_RST_REL:    cur_len = seg_len(owm_pkg::RESET_RELEASE_US);
      PH_PRES_WAIT:  cur_len = seg_len(cfg[owm_pkg::REG_PRES_WAIT]);
      PH_WR_LOW:     cur_len = cur_bit ? seg_len(cfg[owm_pkg::REG_WR1_LOW])
                                       : seg_len(cfg[owm_pkg::REG_WR0_LOW]);
      PH_WR_HIGH:    cur_len = cur_bit ? seg_len(cfg[owm_pkg::REG_WR1_HIGH])
                                       : seg_len(owm_pkg::ZERO_RELEASE_US);
      PH_RD_LOW:     cur_len = seg_len(owm_pkg::READ_LOW_US);
      PH_RD_REL:     cur_len = seg_len(cfg[owm_pkg::REG_RD_SAMPLE]);
      PH_RD_RECOVER: cur_len = seg_len(cfg[owm_pkg::REG_RD_RECOVER]);
      default:       cur_len = seg_len(cfg[owm_pkg::REG_PRES_MAX]);
    endcase
  end

  assign seg_end = (tnext >= {1'b0, cur_len});

  // next state for one word
  always_comb begin
    phase_next          = phase;
    slot_timer_next     = slot_timer;
    bit_index_next      = bit_index;
    shift_data_next     = shift_data;
    active_command_next = active_command;
    error_flag_next     = error_flag;
    done                = 1'b0;

    if (!it.is_tick) begin
      // command word, ignored while busy
      if (phase == PH_IDLE && it.start_ok) begin
        active_command_next = it.command;
        bit_index_next      = '0;
        slot_timer_next     = '0;
        case (it.command)
          owm_pkg::CMD_RESET: begin
            error_flag_next = 1'b0;
            shift_data_next = '0;
            phase_next      = PH_RST_LOW;
          end
          owm_pkg::CMD_WR_BYTE: begin
            shift_data_next = it.write_data;
            phase_next      = PH_WR_LOW;
          end
          owm_pkg::CMD_WR_BIT: begin
            shift_data_next = {7'd0, it.write_data[0]};
            phase_next      = PH_WR_LOW;
          end
          default: begin
            shift_data_next = '0;
            phase_next      = PH_RD_LOW;
          end
        endcase
      end
    end else begin
      case (phase)
        PH_IDLE: begin
        end
        PH_RST_LOW, PH_RST_REL, PH_WR_LOW, PH_RD_LOW: begin
          if (seg_end) begin
            slot_timer_next = '0;
            case (phase)
              PH_RST_LOW: phase_next = PH_RST_REL;
              PH_RST_REL: phase_next = PH_PRES_WAIT;
              PH_WR_LOW:  phase_next = PH_WR_HIGH;
              default:    phase_next = PH_RD_REL;
            endcase
          end else begin
            slot_timer_next = tnext[TIMER_BITS-1:0];
          end
        end
        PH_PRES_WAIT: begin
          if (it.line_level) begin
            if (seg_end) begin
              error_flag_next = 1'b1;
              phase_next      = PH_IDLE;
              slot_timer_next = '0;
              done            = 1'b1;
            end else begin
              slot_timer_next = tnext[TIMER_BITS-1:0];
            end
          end else if (TIMER_BITS'(1) >= seg_len(cfg[owm_pkg::REG_PRES_MAX])) begin
            // first low tick already reaches the limit
            error_flag_next = 1'b1;
            phase_next      = PH_IDLE;
            slot_timer_next = '0;
            done            = 1'b1;
          end else begin
            phase_next      = PH_PRES_LOW;
            slot_timer_next = TIMER_BITS'(1);
          end
        end
        PH_PRES_LOW: begin
          if (it.line_level && slot_timer != '0) begin
            phase_next      = PH_IDLE;
            slot_timer_next = '0;
            done            = 1'b1;
          end else if (seg_end) begin
            error_flag_next = 1'b1;
            phase_next      = PH_IDLE;
            slot_timer_next = '0;
            done            = 1'b1;
          end else begin
            slot_timer_next = tnext[TIMER_BITS-1:0];
          end
        end
        PH_RD_REL: begin
          if (seg_end) begin
            slot_timer_next = '0;
            phase_next      = PH_RD_RECOVER;
            case (active_command)
              owm_pkg::CMD_RD_BYTE:
                shift_data_next = shift_data | (8'(it.line_level) << bit_index[2:0]);
              owm_pkg::CMD_RD_2BITS:
                shift_data_next = {shift_data[6:0], it.line_level};
              default:
                shift_data_next = {7'd0, it.line_level};
            endcase
          end else begin
            slot_timer_next = tnext[TIMER_BITS-1:0];
          end
        end
        PH_WR_HIGH, PH_RD_RECOVER: begin
          if (seg_end) begin
            slot_timer_next = '0;
            if (phase == PH_WR_HIGH) begin
              shift_data_next = {1'b0, shift_data[7:1]};
            end
            bit_index_next = bit_index + 4'd1;
            if ((bit_index + 4'd1) >= bits_total) begin
              phase_next = PH_IDLE;
              done       = 1'b1;
            end else if (active_command == owm_pkg::CMD_WR_BYTE ||
                         active_command == owm_pkg::CMD_WR_BIT) begin
              phase_next = PH_WR_LOW;
            end else begin
              phase_next = PH_RD_LOW;
            end
          end else begin
            slot_timer_next = tnext[TIMER_BITS-1:0];
          end
        end
        default: begin
          phase_next      = PH_IDLE;
          slot_timer_next = '0;
        end
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      slot_timer     <= '0;
      bit_index      <= '0;
      shift_data     <= '0;
      active_command <= owm_pkg::CMD_RESET;
      error_flag     <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      slot_timer     <= slot_timer_next;
      bit_index      <= bit_index_next;
      shift_data     <= shift_data_next;
      active_command <= active_command_next;
      error_flag     <= error_flag_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (step) begin
      drive_low   <= (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW) ||
                     (phase_next == PH_RD_LOW);
      busy_res    <= (phase_next != PH_IDLE);
      done_res    <= done;
      read_data   <= (done && (active_command_next == owm_pkg::CMD_RD_BYTE ||
                               active_command_next == owm_pkg::CMD_RD_BIT ||
                               active_command_next == owm_pkg::CMD_RD_2BITS))
                     ? shift_data_next : 8'd0;
      no_presence <= error_flag_next;
    end
  end

endmodule

// ===== src/one_wire_bus_master_core.sv =====
// Top level of the single-wire bus master: register file and the two parts.
//
//   port group   direction  handshake          content
//   input        in         in_valid/in_ready  kind, command, write_data, line_level
//   output       out        out_valid/out_ready drive_low, busy_res, done_res,
//                                              read_data, no_presence
//   config       in/out     APB psel/penable   eight 10-bit timing registers
//
// One word per clock sustained while the output is not stalled; a taken word
// waits in the two-entry queue, then one sequencer step loads its result into
// the result register.
// The sequencer takes one queued word per clock while the result register
// is empty or being drained.
// Synchronous reset empties the queue, idles the sequencer, loads defaults.
// A stalled output holds the result; the queue keeps taking up to two words.
module one_wire_bus_master_core #(
  parameter int TIMER_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [2:0]  command,
  input  logic [7:0]  write_data,
  input  logic        line_level,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic        drive_low,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_data,
  output logic        no_presence,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  owm_pkg::cfg_regs_t  cfg;
  owm_pkg::queue_out_t q_out;
  logic                q_pop;
  logic [2:0]          reg_idx;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;
  assign prdata  = {22'd0, cfg[reg_idx]};

  // timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[owm_pkg::REG_RESET_LOW]  <= 10'd480;
      cfg[owm_pkg::REG_PRES_WAIT]  <= 10'd100;
      cfg[owm_pkg::REG_PRES_MAX]   <= 10'd240;
      cfg[owm_pkg::REG_WR1_LOW]    <= 10'd10;
      cfg[owm_pkg::REG_WR1_HIGH]   <= 10'd50;
      cfg[owm_pkg::REG_WR0_LOW]    <= 10'd60;
      cfg[owm_pkg::REG_RD_SAMPLE]  <= 10'd12;
      cfg[owm_pkg::REG_RD_RECOVER] <= 10'd50;
    end else if (psel && penable && pwrite && pready) begin
      cfg[reg_idx] <= pwdata[owm_pkg::REG_BITS-1:0];
    end
  end

  owm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .command    (command),
    .write_data (write_data),
    .line_level (line_level),
    .q_out      (q_out),
    .q_pop      (q_pop)
  );

  owm_back #(
    .TIMER_BITS (TIMER_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_out       (q_out),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .drive_low   (drive_low),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .read_data   (read_data),
    .no_presence (no_presence)
  );

endmodule

// ===== verif/one_wire_bus_master_core_test.sv =====
// Self-checking testbench for the single-wire bus master core.
`timescale 1ns / 1ps

module one_wire_bus_master_core_test;

  localparam int TIMER_BITS = 10;
  localparam int unsigned TICK_MAX = (1 << TIMER_BITS) - 1;
  localparam int STALL_LIMIT = 4000;
  localparam int PRINT_LIMIT = 40;

  // sequencer phases of the predictor
  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_REL, SEQ_PRES_WAIT, SEQ_PRES_LOW,
    SEQ_WR_LOW, SEQ_WR_HIGH, SEQ_RD_LOW, SEQ_RD_REL, SEQ_RD_RECOVER
  } seq_phase_t;

  typedef struct {
    seq_phase_t  ph;
    int unsigned timer;
    logic [3:0]  bit_idx;
    logic [7:0]  shreg;
    logic [2:0]  act;
    logic        err;
  } seq_state_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] command;
    logic [7:0] wdata;
    logic       level;
  } in_word_t;

  typedef struct packed {
    logic       drive;
    logic       busy;
    logic       done;
    logic [7:0] rdata;
    logic       nopres;
  } bus_result_t;

  localparam logic WORD_CMD  = 1'b0;
  localparam logic WORD_TICK = 1'b1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = 1'b0;
  logic [2:0]  command = '0;
  logic [7:0]  write_data = '0;
  logic        line_level = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        drive_low;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  read_data;
  logic        no_presence;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned timing [owm_pkg::REG_COUNT];
  seq_state_t  check_state;
  seq_state_t  plan_state;
  in_word_t    pending_words [$];
  bus_result_t expected_results [$];
  int          mismatches = 0;
  int          phase_words = 0;
  int          gap_left = 0;
  int          burst_left = 1;
  int          stall_mode = 0;
  int          stall_len = 0;
  int          quiet_cycles = 0;
  in_word_t    taken_word;
  in_word_t    next_word;
  bus_result_t want;
  bus_result_t got;

  one_wire_bus_master_core #(.TIMER_BITS(TIMER_BITS)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .command(command), .write_data(write_data), .line_level(line_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .drive_low(drive_low), .busy_res(busy_res), .done_res(done_res),
    .read_data(read_data), .no_presence(no_presence),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    if (mismatches < PRINT_LIMIT) $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------- predictor

  // timing register value as a segment length in ticks
  function automatic int unsigned seg_ticks(input int unsigned v);
    if (v == 0) return 1;
    if (v > TICK_MAX) return TICK_MAX;
    return v;
  endfunction

  // count one tick of a segment; true when the segment has ended
  function automatic logic timer_hit(inout seq_state_t s, input int unsigned len);
    if (s.timer + 1 >= seg_ticks(len)) begin
      s.timer = 0;
      return 1'b1;
    end
    s.timer = s.timer + 1;
    return 1'b0;
  endfunction

  function automatic void slot_begin(inout seq_state_t s);
    s.timer = 0;
    s.ph = (s.act == owm_pkg::CMD_WR_BYTE || s.act == owm_pkg::CMD_WR_BIT) ?
           SEQ_WR_LOW : SEQ_RD_LOW;
  endfunction

  // close a bit slot; true when the whole operation is over
  function automatic logic bit_finish(inout seq_state_t s);
    int unsigned nbits;
    s.bit_idx = s.bit_idx + 4'd1;
    if (s.act == owm_pkg::CMD_WR_BYTE || s.act == owm_pkg::CMD_RD_BYTE) nbits = 8;
    else if (s.act == owm_pkg::CMD_RD_2BITS) nbits = 2;
    else nbits = 1;
    if (s.bit_idx >= nbits) begin
      s.ph = SEQ_IDLE;
      s.timer = 0;
      return 1'b1;
    end
    slot_begin(s);
    return 1'b0;
  endfunction

  // one more low tick of the presence pulse
  function automatic logic pres_low_tick(inout seq_state_t s);
    if (s.timer + 1 >= seg_ticks(timing[owm_pkg::REG_PRES_MAX])) begin
      s.err = 1'b1;
      s.ph = SEQ_IDLE;
      s.timer = 0;
      return 1'b1;
    end
    s.timer = s.timer + 1;
    return 1'b0;
  endfunction

  function automatic logic seq_tick(inout seq_state_t s, input logic lvl);
    logic b;
    logic done;
    b = s.shreg[0];
    done = 1'b0;
    case (s.ph)
      SEQ_RST_LOW:
        if (timer_hit(s, timing[owm_pkg::REG_RESET_LOW])) s.ph = SEQ_RST_REL;
      SEQ_RST_REL:
        if (timer_hit(s, owm_pkg::RESET_RELEASE_US)) s.ph = SEQ_PRES_WAIT;
      SEQ_PRES_WAIT: begin
        if (lvl) begin
          if (s.timer + 1 >= seg_ticks(timing[owm_pkg::REG_PRES_WAIT])) begin
            s.err = 1'b1;
            s.ph = SEQ_IDLE;
            s.timer = 0;
            done = 1'b1;
          end else begin
            s.timer = s.timer + 1;
          end
        end else begin
          // first low tick already counts toward the pulse length
          s.timer = 0;
          s.ph = SEQ_PRES_LOW;
          done = pres_low_tick(s);
        end
      end
      SEQ_PRES_LOW: begin
        if (lvl && s.timer != 0) begin
          s.ph = SEQ_IDLE;
          s.timer = 0;
          done = 1'b1;
        end else begin
          done = pres_low_tick(s);
        end
      end
      SEQ_WR_LOW:
        if (timer_hit(s, b ? timing[owm_pkg::REG_WR1_LOW] : timing[owm_pkg::REG_WR0_LOW]))
          s.ph = SEQ_WR_HIGH;
      SEQ_WR_HIGH: begin
        if (timer_hit(s, b ? timing[owm_pkg::REG_WR1_HIGH] : owm_pkg::ZERO_RELEASE_US)) begin
          s.shreg = s.shreg >> 1;
          done = bit_finish(s);
        end
      end
      SEQ_RD_LOW: if (timer_hit(s, owm_pkg::READ_LOW_US)) s.ph = SEQ_RD_REL;
      SEQ_RD_REL: begin
        if (timer_hit(s, timing[owm_pkg::REG_RD_SAMPLE])) begin
          if (s.act == owm_pkg::CMD_RD_BYTE)
            s.shreg[s.bit_idx[2:0]] = s.shreg[s.bit_idx[2:0]] | lvl;
          else if (s.act == owm_pkg::CMD_RD_2BITS) s.shreg = {s.shreg[6:0], lvl};
          else s.shreg = {7'd0, lvl};
          s.ph = SEQ_RD_RECOVER;
        end
      end
      SEQ_RD_RECOVER:
        if (timer_hit(s, timing[owm_pkg::REG_RD_RECOVER])) done = bit_finish(s);
      default: begin
        s.ph = SEQ_IDLE;
        s.timer = 0;
      end
    endcase
    return done;
  endfunction

  // result word that the master returns for one input word
  function automatic bus_result_t seq_step(inout seq_state_t s, input in_word_t w);
    bus_result_t r;
    logic done;
    done = 1'b0;
    if (w.kind == WORD_CMD) begin
      if (s.ph == SEQ_IDLE && w.command <= owm_pkg::CMD_RD_2BITS) begin
        s.act = w.command;
        s.bit_idx = '0;
        s.timer = 0;
        if (w.command == owm_pkg::CMD_RESET) begin
          s.err = 1'b0;
          s.shreg = 8'd0;
          s.ph = SEQ_RST_LOW;
        end else begin
          if (w.command == owm_pkg::CMD_WR_BYTE) s.shreg = w.wdata;
          else if (w.command == owm_pkg::CMD_WR_BIT) s.shreg = {7'd0, w.wdata[0]};
          else s.shreg = 8'd0;
          slot_begin(s);
        end
      end
    end else if (s.ph != SEQ_IDLE) begin
      done = seq_tick(s, w.level);
    end
    r.drive = (s.ph == SEQ_RST_LOW || s.ph == SEQ_WR_LOW || s.ph == SEQ_RD_LOW);
    r.busy = (s.ph != SEQ_IDLE);
    r.done = done;
    r.rdata = (done && (s.act == owm_pkg::CMD_RD_BYTE || s.act == owm_pkg::CMD_RD_BIT ||
               s.act == owm_pkg::CMD_RD_2BITS)) ? s.shreg : 8'd0;
    r.nopres = s.err;
    return r;
  endfunction

  function automatic void state_clear(output seq_state_t s);
    s.ph = SEQ_IDLE;
    s.timer = 0;
    s.bit_idx = '0;
    s.shreg = '0;
    s.act = '0;
    s.err = 1'b0;
  endfunction

  // ---------------------------------------------------------------- driver

  // input words: bursts with random gaps, fed from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken_word = {kind, command, write_data, line_level};
        expected_results.push_back(seq_step(check_state, taken_word));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || pending_words.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          next_word = pending_words.pop_front();
          kind <= next_word.kind;
          command <= next_word.command;
          write_data <= next_word.wdata;
          line_level <= next_word.level;
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  // result words: field compare against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {drive_low, busy_res, done_res, read_data, no_presence};
        if (expected_results.size() == 0) begin
          report($sformatf("result word with nothing expected: %h", got));
        end else begin
          want = expected_results.pop_front();
          if (got.drive !== want.drive)
            report($sformatf("drive_low got %b want %b", got.drive, want.drive));
          if (got.busy !== want.busy)
            report($sformatf("busy_res got %b want %b", got.busy, want.busy));
          if (got.done !== want.done)
            report($sformatf("done_res got %b want %b", got.done, want.done));
          if (got.rdata !== want.rdata)
            report($sformatf("read_data got %h want %h", got.rdata, want.rdata));
          if (got.nopres !== want.nopres)
            report($sformatf("no_presence got %b want %b", got.nopres, want.nopres));
        end
      end
      // receiver stall pattern: modes of random length
      if (stall_len > 0) begin
        stall_len--;
      end else begin
        stall_mode = $urandom_range(0, 3);
        stall_len = $urandom_range(20, 200);
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // watchdog on cycles without any traffic
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_word(input logic k, input logic [2:0] c, input logic [7:0] d,
                           input logic l);
    in_word_t w;
    w = {k, c, d, l};
    void'(seq_step(plan_state, w));
    pending_words.push_back(w);
    phase_words++;
  endtask

  // one operation: the command word, then ticks until the sequencer is idle;
  // hi/lo shape the presence answer (high ticks first, then low ticks)
  task automatic run_op(input logic [2:0] c, input logic [7:0] d, input int hi,
                        input int lo);
    logic lvl;
    push_word(WORD_CMD, c, d, 1'($urandom_range(0, 1)));
    while (plan_state.ph != SEQ_IDLE) begin
      if ($urandom_range(0, 15) == 0) begin
        // command while busy, must be ignored
        push_word(WORD_CMD, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else begin
        if (plan_state.ph == SEQ_PRES_WAIT || plan_state.ph == SEQ_PRES_LOW) begin
          if (hi > 0) begin
            lvl = 1'b1;
            hi--;
          end else if (lo > 0) begin
            lvl = 1'b0;
            lo--;
          end else begin
            lvl = 1'b1;
          end
        end else begin
          lvl = 1'($urandom_range(0, 1));
        end
        push_word(WORD_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), lvl);
      end
    end
  endtask

  task automatic random_op();
    int r;
    r = $urandom_range(0, 15);
    if (r < 14) begin
      run_op(3'(r % 6), 8'($urandom_range(0, 255)),
             int'($urandom_range(0, seg_ticks(timing[owm_pkg::REG_PRES_WAIT]) + 1)),
             int'($urandom_range(0, seg_ticks(timing[owm_pkg::REG_PRES_MAX]) + 1)));
    end else if (r == 14) begin
      push_word(WORD_CMD, 3'($urandom_range(6, 7)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    end else begin
      repeat ($urandom_range(1, 4))
        push_word(WORD_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    end
  endtask

  // APB setup and access cycle; reads are checked against the stored value
  task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) timing[idx] = 32'(data[owm_pkg::REG_BITS-1:0]);
    else if (prdata !== {22'd0, timing[idx][owm_pkg::REG_BITS-1:0]})
      report($sformatf("register %0d read %h want %h", idx, prdata, timing[idx]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    logic [31:0] data;
    data = $urandom;
    data[owm_pkg::REG_BITS-1:0] = owm_pkg::REG_BITS'(val);
    apb_access(1'b1, idx, data);
    apb_access(1'b0, idx, 32'd0);
  endtask

  // sender stops until every expected word has come back
  task automatic wait_for_quiet();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  initial begin : stimulus
    int unsigned v;
    int p;
    int i;
    state_clear(check_state);
    state_clear(plan_state);
    timing = '{480, 100, 240, 10, 50, 60, 12, 50};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // register values after reset
    for (i = 0; i < owm_pkg::REG_COUNT; i++) apb_access(1'b0, 3'(i), 32'd0);

    // default timings: single-bit slots
    run_op(owm_pkg::CMD_WR_BIT, 8'h01, 0, 0);
    run_op(owm_pkg::CMD_WR_BIT, 8'h00, 0, 0);
    run_op(owm_pkg::CMD_RD_BIT, 8'h00, 0, 0);
    wait_for_quiet();

    // shortest slots, short presence window: every operation and corner
    for (i = 0; i < owm_pkg::REG_COUNT; i++)
      write_reg(3'(i), (i == owm_pkg::REG_PRES_WAIT || i == owm_pkg::REG_PRES_MAX) ? 4 : 1);
    push_word(WORD_TICK, 3'd0, 8'h00, 1'b0);
    push_word(WORD_TICK, 3'd7, 8'hFF, 1'b1);
    push_word(WORD_CMD, 3'd6, 8'h00, 1'b0);
    push_word(WORD_CMD, 3'd7, 8'hFF, 1'b1);
    run_op(owm_pkg::CMD_WR_BYTE, 8'hFF, 0, 0);
    run_op(owm_pkg::CMD_WR_BYTE, 8'h00, 0, 0);
    run_op(owm_pkg::CMD_RD_BYTE, 8'h00, 0, 0);
    run_op(owm_pkg::CMD_RD_2BITS, 8'h00, 0, 0);
    run_op(owm_pkg::CMD_WR_BIT, 8'hFE, 0, 0);
    run_op(owm_pkg::CMD_WR_BIT, 8'h01, 0, 0);
    run_op(owm_pkg::CMD_RD_BIT, 8'h00, 0, 0);
    run_op(owm_pkg::CMD_RESET, 8'h00, 2, 2);
    run_op(owm_pkg::CMD_RESET, 8'h00, 10, 0);
    run_op(owm_pkg::CMD_RESET, 8'h00, 0, 10);
    wait_for_quiet();

    // zero in every register acts as one tick
    for (i = 0; i < owm_pkg::REG_COUNT; i++) write_reg(3'(i), 0);
    run_op(owm_pkg::CMD_WR_BYTE, 8'($urandom_range(0, 255)), 0, 0);
    run_op(owm_pkg::CMD_RD_BYTE, 8'h00, 0, 0);
    run_op(owm_pkg::CMD_RESET, 8'h00, 0, 0);
    run_op(owm_pkg::CMD_RESET, 8'h00, 0, 1);
    wait_for_quiet();

    // random timings, mostly small, with random operation streams
    for (p = 0; p < 4; p++) begin
      for (i = 0; i < owm_pkg::REG_COUNT; i++) begin
        v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 5);
        write_reg(3'(i), v);
      end
      phase_words = 0;
      while (phase_words < 80) random_op();
      wait_for_quiet();
    end

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      report($sformatf("%0d result words never arrived", expected_results.size()));
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
